### hw/rtl/psnap_pkg.sv
// ----------------------------------------------------------------------------
// psnap_pkg
// Shared types, constants and the reset preset of the pitch-bend step table.
// ----------------------------------------------------------------------------
package psnap_pkg;

	// step table geometry
	localparam int NUM_STEPS  = 25;
	localparam int PRESET_LEN = 25;
	localparam int IDX_W      = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

	// queue between the front and back parts
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// midi constants
	localparam logic [4:0] CHAN_OMNI      = 5'd16;
	localparam logic [3:0] KIND_PITCHBEND = 4'hE;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [13:0]      bend_t;

	// one step table entry
	typedef struct packed {
		logic  enable;
		bend_t value;
	} step_t;

	// what the back part has to do with a queued transaction
	typedef enum logic [1:0] {
		OP_WRITE,
		OP_PASS,
		OP_BEND
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] status_byte;
		logic [7:0] data_first;
		logic [7:0] data_second;
		logic [4:0] step_index;
		bend_t      value;
		logic       step_enable;
	} item_t;

	// equal-spacing preset, top of range at entry 0
	function automatic bend_t preset_value(input int i);
		bend_t v;
		case (i)
			0:       v = 14'd16383;
			1:       v = 14'd15700;
			2:       v = 14'd15018;
			3:       v = 14'd14335;
			4:       v = 14'd13653;
			5:       v = 14'd12970;
			6:       v = 14'd12287;
			7:       v = 14'd11605;
			8:       v = 14'd10922;
			9:       v = 14'd10239;
			10:      v = 14'd9557;
			11:      v = 14'd8874;
			12:      v = 14'd8192;
			13:      v = 14'd7509;
			14:      v = 14'd6826;
			15:      v = 14'd6144;
			16:      v = 14'd5461;
			17:      v = 14'd4778;
			18:      v = 14'd4096;
			19:      v = 14'd3413;
			20:      v = 14'd2731;
			21:      v = 14'd2048;
			22:      v = 14'd1365;
			23:      v = 14'd683;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/pitch_bend_nearest_step_snap.sv
// ----------------------------------------------------------------------------
// pitch_bend_nearest_step_snap
// MIDI channel filter and pitch-bend snapper to the nearest enabled step.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  action, status_byte, data bytes,
//                                            step_index, step_value, step_enable
//   out      output     out_valid/out_stall  out_status, out_data_first/second
//   cfg      input      cfg_wr_en            cfg_wr_data (listen channel)
//
// In the back part a pitch-bend is taken from the queue, every table entry
// is scanned in turn, and the result is finished in the done state, which
// waits for a free output slot; other messages and table writes are handled
// when taken. A two-entry queue lets the front keep accepting while the back
// scans or the output is stalled. Reset restores the preset table and sets
// the listen channel to any. in_stall is high only while the queue is full.
// ----------------------------------------------------------------------------
module pitch_bend_nearest_step_snap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  status_byte,
	input  logic [7:0]  data_first,
	input  logic [7:0]  data_second,
	input  logic [4:0]  step_index,
	input  logic [13:0] step_value,
	input  logic        step_enable,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_status,
	output logic [7:0]  out_data_first,
	output logic [7:0]  out_data_second,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data
);
	import psnap_pkg::*;

	logic  push;
	item_t push_item;
	logic  full;
	logic  pop;
	logic  head_valid;
	item_t head_item;

	// classifier
	psnap_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.status_byte (status_byte),
		.data_first  (data_first),
		.data_second (data_second),
		.step_index  (step_index),
		.step_value  (step_value),
		.step_enable (step_enable),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.push_item   (push_item),
		.full        (full)
	);

	// decoupling queue
	psnap_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// table and scanner
	psnap_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head_item       (head_item),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_status      (out_status),
		.out_data_first  (out_data_first),
		.out_data_second (out_data_second)
	);

endmodule

### hw/rtl/psnap_front.sv
// ----------------------------------------------------------------------------
// psnap_front
// Accepts transactions, filters by listen channel and classifies them into
// table writes, pass-through messages and pitch-bend snaps for the queue.
// ----------------------------------------------------------------------------
module psnap_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [7:0]          status_byte,
	input  logic [7:0]          data_first,
	input  logic [7:0]          data_second,
	input  logic [4:0]          step_index,
	input  logic [13:0]         step_value,
	input  logic                step_enable,
	input  logic                cfg_wr_en,
	input  logic [4:0]          cfg_wr_data,
	output logic                push,
	output psnap_pkg::item_t    push_item,
	input  logic                full
);
	import psnap_pkg::*;

	logic [4:0] listen_channel_q;
	logic       accept;
	logic       chan_ok;
	logic       idx_ok;
	logic       keep;

	// listen channel register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_channel_q <= CHAN_OMNI;
		end else if (cfg_wr_en) begin
			listen_channel_q <= cfg_wr_data;
		end
	end

	// accept whenever the queue has room; filtered transactions just vanish
	assign in_stall = full;
	assign accept   = in_valid && !full;

	// classification
	always_comb begin
		chan_ok = (listen_channel_q >= CHAN_OMNI) ||
		          (status_byte[3:0] == listen_channel_q[3:0]);
		idx_ok  = (32'(step_index) < NUM_STEPS);
		keep    = action ? idx_ok : chan_ok;

		push_item             = '0;
		push_item.status_byte = status_byte;
		push_item.data_first  = data_first;
		push_item.data_second = data_second;
		push_item.step_index  = step_index;
		push_item.step_enable = step_enable;
		if (action) begin
			push_item.op    = OP_WRITE;
			push_item.value = step_value;
		end else if (status_byte[7:4] == KIND_PITCHBEND) begin
			push_item.op    = OP_BEND;
			push_item.value = {data_second[6:0], data_first[6:0]};
		end else begin
			push_item.op    = OP_PASS;
			push_item.value = step_value;
		end
	end

	assign push = accept && keep;

endmodule

### hw/rtl/psnap_fifo.sv
// ----------------------------------------------------------------------------
// psnap_fifo
// Short queue that decouples the front classifier from the back scanner.
// ----------------------------------------------------------------------------
module psnap_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  psnap_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output psnap_pkg::item_t head_item
);
	import psnap_pkg::*;

	typedef logic [QPTR_W-1:0] ptr_t;

	item_t             entry_q [QUEUE_DEPTH];
	ptr_t              wr_ptr_q;
	ptr_t              rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic ptr_t ptr_next(input ptr_t p);
		return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

### hw/rtl/psnap_back.sv
// ----------------------------------------------------------------------------
// psnap_back
// Holds the step table, applies table writes and scans the table one entry a
// cycle to snap a pitch bend to the nearest enabled step; drives the output
// register.
// ----------------------------------------------------------------------------
module psnap_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  psnap_pkg::item_t head_item,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_status,
	output logic [7:0]       out_data_first,
	output logic [7:0]       out_data_second
);
	import psnap_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t     state_q;
	step_t      table_q [NUM_STEPS];
	idx_t       scan_idx_q;
	bend_t      bend_q;
	logic [7:0] status_q;
	logic       found_q;
	bend_t      best_value_q;
	bend_t      best_dist_q;
	logic       out_valid_q;
	logic [7:0] out_status_q;
	logic [7:0] out_data_first_q;
	logic [7:0] out_data_second_q;

	logic       out_free;
	logic       load_out;
	logic       wr_table;
	step_t      cur;
	bend_t      delta;
	logic       better;

	assign out_free = !out_valid_q || !out_stall;

	// take the head transaction when idle; pass-through messages need a free output slot
	always_comb begin
		pop = 1'b0;
		if (state_q == ST_IDLE && head_valid) begin
			case (head_item.op) inside
				OP_WRITE, OP_BEND: pop = 1'b1;
				OP_PASS:           pop = out_free;
				default:           pop = 1'b0;
			endcase
		end
	end

	assign wr_table = pop && (head_item.op == OP_WRITE);

	// a new output transaction enters the output register
	assign load_out = (state_q == ST_IDLE && pop && head_item.op == OP_PASS) ||
	                  (state_q == ST_DONE && out_free && found_q);

	// distance of the current entry to the bend value
	always_comb begin
		cur    = table_q[scan_idx_q];
		delta  = (cur.value >= bend_q) ? (cur.value - bend_q) : (bend_q - cur.value);
		better = cur.enable && (!found_q || (delta < best_dist_q));
	end

	// step table, reset to the preset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STEPS; i++) begin
				table_q[i].value  <= preset_value(i);
				table_q[i].enable <= (i < PRESET_LEN);
			end
		end else if (wr_table) begin
			table_q[idx_t'(head_item.step_index)].value  <= head_item.value;
			table_q[idx_t'(head_item.step_index)].enable <= head_item.step_enable;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			out_valid_q       <= 1'b0;
			scan_idx_q        <= '0;
			found_q           <= 1'b0;
			bend_q            <= '0;
			status_q          <= '0;
			best_value_q      <= '0;
			best_dist_q       <= '0;
			out_status_q      <= '0;
			out_data_first_q  <= '0;
			out_data_second_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head_item.op == OP_PASS) begin
						out_status_q      <= head_item.status_byte;
						out_data_first_q  <= head_item.data_first;
						out_data_second_q <= head_item.data_second;
					end else if (pop && head_item.op == OP_BEND) begin
						status_q   <= head_item.status_byte;
						bend_q     <= head_item.value;
						scan_idx_q <= '0;
						found_q    <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (better) begin
						found_q      <= 1'b1;
						best_value_q <= cur.value;
						best_dist_q  <= delta;
					end
					if (scan_idx_q == idx_t'(NUM_STEPS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						scan_idx_q <= scan_idx_q + idx_t'(1);
					end
				end
				ST_DONE: begin
					// no enabled entry means the bend is dropped
					if (out_free) begin
						if (found_q) begin
							out_status_q      <= status_q;
							out_data_first_q  <= {1'b0, best_value_q[6:0]};
							out_data_second_q <= {1'b0, best_value_q[13:7]};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_data_first  = out_data_first_q;
	assign out_data_second = out_data_second_q;

endmodule

### hw/rtl/psnap_checker.sv
// ----------------------------------------------------------------------------
// psnap_checker
// Port-level checks of the snapper, bound to the top level.
// ----------------------------------------------------------------------------
module psnap_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_status,
	input logic [7:0] out_data_first,
	input logic [7:0] out_data_second,
	input logic       cfg_wr_en,
	input logic [4:0] cfg_wr_data
);
	import psnap_pkg::*;

	logic [4:0] chan_q;

	// mirror of the listen channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= CHAN_OMNI;
		end else if (cfg_wr_en) begin
			chan_q <= cfg_wr_data;
		end
	end

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_status) &&
		$stable(out_data_first) && $stable(out_data_second))
		else $error("output transaction changed while stalled");

	// snapped bends carry 7-bit data bytes
	a_bend_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status[7:4] == KIND_PITCHBEND) |->
		!out_data_first[7] && !out_data_second[7])
		else $error("pitch bend result with data bit 7 set");

	// only the listened channel comes out
	a_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (chan_q < CHAN_OMNI) |-> out_status[3:0] == chan_q[3:0])
		else $error("result on a filtered channel");

endmodule

bind pitch_bend_nearest_step_snap psnap_checker u_psnap_checker (.*);
